FILE: sv/sidt_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
// Used by the conversion stages, the character serializer and the top level.
`default_nettype none

package sidt_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 7;
    localparam int DIGITS         = 10;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = DIGITS * DIGIT_W;
    localparam int BITS_PER_STAGE = 4;
    localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;
    localparam int IDX_W          = 4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    // One number on its way through the binary to BCD conversion.
    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_work;

endpackage

`default_nettype wire

FILE: sv/sidt_dabble_stage.sv
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
// Depends on sidt_pkg for the work word layout and stage sizing.
`default_nettype none

module sidt_dabble_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire sidt_pkg::t_work i_work,
    output logic                o_valid,
    input  wire logic           i_ready,
    output sidt_pkg::t_work     o_work
);

    logic                          r_valid;
    sidt_pkg::t_work               r_work;
    sidt_pkg::t_work               n_work;
    logic [sidt_pkg::BCD_W-1:0]    v_bcd;
    logic [sidt_pkg::VALUE_W-1:0]  v_bin;

    // Each step corrects every digit that would overflow on doubling,
    // then shifts one binary bit into the BCD field.
    always_comb begin
        v_bcd = i_work.bcd;
        v_bin = i_work.bin;
        for (int it = 0; it < sidt_pkg::BITS_PER_STAGE; it++) begin
            for (int d = 0; d < sidt_pkg::DIGITS; d++) begin
                if (v_bcd[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] >= 4'd5) begin
                    v_bcd[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] =
                        v_bcd[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] + 4'd3;
                end
            end
            {v_bcd, v_bin} = {v_bcd[sidt_pkg::BCD_W-2:0], v_bin, 1'b0};
        end
        n_work.neg = i_work.neg;
        n_work.bcd = v_bcd;
        n_work.bin = v_bin;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

`default_nettype wire

FILE: sv/sidt_serializer.sv
// Emits the text of one converted number, one character per transaction.
// Depends on sidt_pkg for the work word layout and character codes.
`default_nettype none

module sidt_serializer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire sidt_pkg::t_work           i_work,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [sidt_pkg::CHAR_W-1:0]    o_char,
    output logic                           o_last
);

    logic                          r_busy;
    logic                          r_sign;
    logic [sidt_pkg::IDX_W-1:0]    r_idx;
    logic [sidt_pkg::BCD_W-1:0]    r_bcd;
    logic [sidt_pkg::IDX_W-1:0]    n_top;
    logic [sidt_pkg::DIGIT_W-1:0]  w_digit;
    logic                          w_take;
    logic                          w_load;

    // Index of the most significant nonzero digit; zero prints one digit.
    always_comb begin
        n_top = '0;
        for (int d = 1; d < sidt_pkg::DIGITS; d++) begin
            if (i_work.bcd[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] != 4'd0) begin
                n_top = sidt_pkg::IDX_W'(d);
            end
        end
    end

    assign w_digit = r_bcd[{r_idx, 2'b00} +: sidt_pkg::DIGIT_W];
    assign o_char  = r_sign ? sidt_pkg::CHAR_MINUS
                            : sidt_pkg::CHAR_ZERO + {3'b000, w_digit};
    assign o_last  = !r_sign && (r_idx == '0);
    assign o_valid = r_busy;

    assign w_take  = r_busy && i_ready;
    assign o_ready = !r_busy || (w_take && o_last);
    assign w_load  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (w_take && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sign <= i_work.neg;
            r_idx  <= n_top;
            r_bcd  <= i_work.bcd;
        end else if (w_take) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_idx <= r_idx - sidt_pkg::IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/signed_int_to_decimal_text.sv
// Signed 32-bit integer to decimal ASCII text, top level.
// Depends on sidt_pkg, sidt_dabble_stage and sidt_serializer.
`default_nettype none

// Each input transaction carries one two's complement integer; the output
// stream returns its decimal text, most significant character first, with a
// leading '-' for negative values, no leading zeros, and tlast on the final
// character. The most negative value prints as -2147483648. The conversion
// runs through a magnitude register and eight shift-and-add-3 stages, and a
// new number can enter that pipeline every cycle unless the output stalls it.
// The output serializer sends one character per cycle while the receiver is
// ready, and loads the next number in the cycle its last character leaves;
// a number's text is 1 to 11 characters long.

module signed_int_to_decimal_text (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic             o_m_axis_tlast
);

    localparam int NS = sidt_pkg::DABBLE_STAGES;

    logic                         r_in_valid;
    sidt_pkg::t_work              r_in_work;
    sidt_pkg::t_work              n_in_work;
    logic                         w_valid [NS+1];
    logic                         w_ready [NS+1];
    sidt_pkg::t_work              w_work  [NS+1];
    logic [sidt_pkg::CHAR_W-1:0]  w_char;

    // Magnitude in unsigned arithmetic, so the most negative value survives.
    always_comb begin
        n_in_work.neg = i_s_axis_tdata[sidt_pkg::VALUE_W-1];
        n_in_work.bcd = '0;
        n_in_work.bin = n_in_work.neg ? (sidt_pkg::VALUE_W'(0) - i_s_axis_tdata)
                                      : i_s_axis_tdata;
    end

    assign o_s_axis_tready = !r_in_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_work <= n_in_work;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_work[0]  = r_in_work;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        sidt_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_work  (w_work[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_work  (w_work[s+1])
        );
    end

    sidt_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NS]),
        .o_ready (w_ready[NS]),
        .i_work  (w_work[NS]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (w_char),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_char};

endmodule

`default_nettype wire

FILE: tb/sv/tb_signed_int_to_decimal_text.sv
// Self-checking testbench for signed_int_to_decimal_text.
// Drives integers into the input stream, predicts or looks up each one's decimal
// text and compares every output character. Needs sidt_pkg and the block's RTL.

module tb_signed_int_to_decimal_text;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS  = 80;
    localparam int HOLD_OFF      = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_char;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    t_char       pending_chars[$];
    string       typed_text[$];
    int          err_count = 0;
    int          in_count = 0;
    bit          held_off = 1'b0;

    signed_int_to_decimal_text DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decimal text of a two's complement value, most significant character first.
    function automatic void predict_decimal_text(input logic [31:0] value);
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  digit [10];
        int          nd;
        t_char       c;
        neg = value[31];
        mag = neg ? (32'd0 - value) : value;
        nd  = 0;
        do begin
            digit[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 32'd0 && nd < 10);
        if (neg) begin
            c.code = sidt_pkg::CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.code = sidt_pkg::CHAR_ZERO + 7'(digit[k]);
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // Directed rows; an empty text means the predictor supplies the answer.
    function automatic void directed_row(input int idx, output logic [31:0] value,
                                         output string text);
        text = "";
        case (idx)
            0:  begin value = 32'd0;          text = "0";           end
            1:  begin value = 32'd1;          text = "1";           end
            2:  begin value = -32'sd1;        text = "-1";          end
            3:  begin value = 32'd9;          text = "9";           end
            4:  begin value = 32'd10;         text = "10";          end
            5:  begin value = -32'sd10;       text = "-10";         end
            6:  begin value = 32'h7FFF_FFFF;  text = "2147483647";  end
            7:  begin value = 32'h8000_0000;  text = "-2147483648"; end
            8:  begin value = 32'h8000_0001;  text = "-2147483647"; end
            9:  begin value = 32'd1000000000; text = "1000000000";  end
            10: value = 32'd999999999;
            11: value = -32'sd999999999;
            12: value = 32'd12345;
            13: value = -32'sd987654321;
            14: value = 32'h5555_5555;
            15: value = 32'hAAAA_AAAA;
            16: value = -32'sd100;
            17: value = 32'd99;
            18: value = 32'd2000000000;
            default: value = -32'sd1000000000;
        endcase
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        longint      pow10;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2: begin
                pow10 = 1;
                repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
                v = 32'(pow10) + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                         + 32'($urandom_range(0, 4)) - 32'd2;
        endcase
        if ($urandom_range(0, 1) && v != 32'h8000_0000)
            v = 32'd0 - v;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 8);
        return $urandom_range(20, 80);
    endfunction

    // Offer one value and return once the transaction has completed.
    task automatic offer(input logic [31:0] value, input string text);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_text.push_back(text);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Input and output monitor: expectations are queued when an input
    // transaction completes and consumed when an output one does.
    always @(posedge clk) begin
        string s;
        byte   ch;
        t_char c;
        t_char want;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                in_count++;
                s = typed_text.pop_front();
                if (s.len() == 0) begin
                    predict_decimal_text(s_tdata);
                end else begin
                    for (int i = 0; i < s.len(); i++) begin
                        ch = s[i];
                        c.code = ch[6:0];
                        c.last = (i == s.len() - 1);
                        pending_chars.push_back(c);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected character: char_code %0d last %0b",
                           m_tdata[6:0], m_tlast);
                    err_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (m_tdata[6:0] !== want.code) begin
                        $error("char_code: expected %0d, got %0d", want.code, m_tdata[6:0]);
                        err_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        err_count++;
                    end
                    if (m_tdata[7] !== 1'b0) begin
                        $error("zero: expected 0, got %0b", m_tdata[7]);
                        err_count++;
                    end
                end
            end
        end
    end

    // Receiver: random ready pattern, with one long hold-off during the random part.
    initial begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_off && in_count >= 40) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat (pick_run()) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [31:0] value;
        string       text;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            directed_row(i, value, text);
            offer(value, text);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
            offer(random_value(), "");
        s_tvalid <= 1'b0;

        // One more edge so the monitor has queued the last input's text.
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0) begin
            $error("%0d expected characters never arrived", pending_chars.size());
            err_count++;
        end

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
